### rtl/core/constant_pad_4d_stream_assert.svh
// ----------------------------------------------------------------------------
// constant_pad_4d_stream assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef CONSTANT_PAD_4D_STREAM_ASSERT_SVH
`define CONSTANT_PAD_4D_STREAM_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CP4D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CP4D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cp4d_pkg.sv
// ----------------------------------------------------------------------------
// cp4d_pkg
// Shared constants and types of the 4-d constant pad stream.
// ----------------------------------------------------------------------------
`default_nettype none

package cp4d_pkg;

	localparam int DIM_BITS_DEF = 12;
	localparam int NUM_DIMS     = 4;
	localparam int VAL_W        = 32;
	localparam int RUN_W        = 55;

	// apb port
	localparam int APB_DW = 64;
	localparam int APB_AW = 6;

	// dimension slots in the packed config bundle
	localparam int DIM_B = 0;
	localparam int DIM_H = 1;
	localparam int DIM_W = 2;
	localparam int DIM_D = 3;

	// register map, one 64-bit slot each
	typedef enum logic [2:0] {
		REG_BATCH,
		REG_HEIGHT,
		REG_WIDTH,
		REG_DEPTH,
		REG_FILL
	} reg_idx_t;

	// pad run slots, in emission order around the element
	localparam int NUM_PADS    = 8;
	localparam int PAD_LEAD_B  = 0;
	localparam int PAD_LEAD_H  = 1;
	localparam int PAD_LEAD_W  = 2;
	localparam int PAD_LEAD_D  = 3;
	localparam int PAD_TRAIL_D = 4;
	localparam int PAD_TRAIL_W = 5;
	localparam int PAD_TRAIL_H = 6;
	localparam int PAD_TRAIL_B = 7;

	// run mask: leading pads, element, trailing pads
	localparam int NUM_RUNS = NUM_PADS + 1;
	localparam int RUN_ELEM = 4;

	typedef enum logic [1:0] {
		RL_IDLE,
		RL_LOAD,
		RL_MUL,
		RL_STORE
	} rl_state_t;

endpackage

`default_nettype wire

### rtl/core/cp4d_apb_regs.sv
// ----------------------------------------------------------------------------
// cp4d_apb_regs
// APB register file: four packed dimension registers and the fill value.
// ----------------------------------------------------------------------------
`default_nettype none

module cp4d_apb_regs #(
	parameter int DIM_BITS = cp4d_pkg::DIM_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       psel,
	input  wire logic                                       penable,
	input  wire logic                                       pwrite,
	input  wire logic [cp4d_pkg::APB_AW-1:0]                paddr,
	input  wire logic [cp4d_pkg::APB_DW-1:0]                pwdata,
	output logic      [cp4d_pkg::APB_DW-1:0]                prdata,
	output logic                                            pready,
	output logic [cp4d_pkg::NUM_DIMS-1:0][3*DIM_BITS-1:0]   dim_cfg,
	output logic      [cp4d_pkg::VAL_W-1:0]                 fill_value,
	output logic                                            cfg_wr
);

	localparam int CFG_W = 3 * DIM_BITS;

	logic [cp4d_pkg::NUM_DIMS-1:0][CFG_W-1:0] dim_cfg_q;
	logic [cp4d_pkg::VAL_W-1:0]               fill_q;
	cp4d_pkg::reg_idx_t                       reg_idx;

	assign reg_idx = cp4d_pkg::reg_idx_t'(paddr[cp4d_pkg::APB_AW-1:3]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < cp4d_pkg::NUM_DIMS; d++) begin
				dim_cfg_q[d] <= CFG_W'(1);
			end
			fill_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				cp4d_pkg::REG_BATCH:  dim_cfg_q[cp4d_pkg::DIM_B] <= pwdata[CFG_W-1:0];
				cp4d_pkg::REG_HEIGHT: dim_cfg_q[cp4d_pkg::DIM_H] <= pwdata[CFG_W-1:0];
				cp4d_pkg::REG_WIDTH:  dim_cfg_q[cp4d_pkg::DIM_W] <= pwdata[CFG_W-1:0];
				cp4d_pkg::REG_DEPTH:  dim_cfg_q[cp4d_pkg::DIM_D] <= pwdata[CFG_W-1:0];
				cp4d_pkg::REG_FILL:   fill_q <= pwdata[cp4d_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cp4d_pkg::REG_BATCH:
				prdata = cp4d_pkg::APB_DW'(dim_cfg_q[cp4d_pkg::DIM_B]);
			cp4d_pkg::REG_HEIGHT:
				prdata = cp4d_pkg::APB_DW'(dim_cfg_q[cp4d_pkg::DIM_H]);
			cp4d_pkg::REG_WIDTH:
				prdata = cp4d_pkg::APB_DW'(dim_cfg_q[cp4d_pkg::DIM_W]);
			cp4d_pkg::REG_DEPTH:
				prdata = cp4d_pkg::APB_DW'(dim_cfg_q[cp4d_pkg::DIM_D]);
			cp4d_pkg::REG_FILL:
				prdata = cp4d_pkg::APB_DW'(fill_q);
			default:
				prdata = '0;
		endcase
	end

	assign dim_cfg    = dim_cfg_q;
	assign fill_value = fill_q;

endmodule

`default_nettype wire

### rtl/core/cp4d_runlen.sv
// ----------------------------------------------------------------------------
// cp4d_runlen
// Pad run length unit: eight fill run lengths, six of them worked out by a shift-add
// multiplier from the dimension registers after reset and each write.
// ----------------------------------------------------------------------------
`default_nettype none

module cp4d_runlen #(
	parameter int DIM_BITS = cp4d_pkg::DIM_BITS_DEF
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             cfg_wr,
	input  wire logic [cp4d_pkg::NUM_DIMS-1:0][3*DIM_BITS-1:0]    dim_cfg,
	output logic      [cp4d_pkg::NUM_PADS-1:0][cp4d_pkg::RUN_W-1:0] pad_len,
	output logic                                                  busy
);

	localparam int CFG_W  = 3 * DIM_BITS;
	localparam int MB     = DIM_BITS + 2;          // padded extent width
	localparam int PW     = cp4d_pkg::RUN_W + MB;  // full product width
	localparam int STEP_W = $clog2(MB);
	localparam int RUN_W  = cp4d_pkg::RUN_W;

	typedef enum logic [2:0] {
		JOB_OWD,
		JOB_OHWD,
		JOB_LEAD_B,
		JOB_LEAD_H,
		JOB_LEAD_W,
		JOB_TRAIL_W,
		JOB_TRAIL_H,
		JOB_TRAIL_B
	} rl_job_t;

	cp4d_pkg::rl_state_t state_q, state_nxt;
	rl_job_t             job_q;
	logic [STEP_W-1:0]   step_q;
	logic [MB-1:0]       mplier_q;
	logic [PW-1:0]       mcand_q;
	logic [PW-1:0]       acc_q;
	logic [RUN_W-1:0]    owd_q, ohwd_q;
	logic [RUN_W-1:0]    len_lb_q, len_lh_q, len_lw_q;
	logic [RUN_W-1:0]    len_tw_q, len_th_q, len_tb_q;

	logic                do_load, do_step, do_store;
	logic                step_last;
	logic [MB-1:0]       op_a;
	logic [RUN_W-1:0]    op_b;
	logic [RUN_W-1:0]    prod_sat;

	logic [cp4d_pkg::NUM_DIMS-1:0][MB-1:0]       ext;
	logic [cp4d_pkg::NUM_DIMS-1:0][DIM_BITS-1:0] lead, trail;

	// padded extent per dimension, zero size counts as one
	always_comb begin
		for (int d = 0; d < cp4d_pkg::NUM_DIMS; d++) begin
			logic [DIM_BITS-1:0] sz;
			sz       = dim_cfg[d][DIM_BITS-1:0];
			lead[d]  = dim_cfg[d][2*DIM_BITS-1:DIM_BITS];
			trail[d] = dim_cfg[d][CFG_W-1:2*DIM_BITS];
			ext[d]   = ((sz == '0) ? MB'(1) : MB'(sz)) + MB'(lead[d]) + MB'(trail[d]);
		end
	end

	always_comb begin
		case (job_q)
			JOB_OWD: begin
				op_a = ext[cp4d_pkg::DIM_W];
				op_b = RUN_W'(ext[cp4d_pkg::DIM_D]);
			end
			JOB_OHWD: begin
				op_a = ext[cp4d_pkg::DIM_H];
				op_b = owd_q;
			end
			JOB_LEAD_B: begin
				op_a = MB'(lead[cp4d_pkg::DIM_B]);
				op_b = ohwd_q;
			end
			JOB_LEAD_H: begin
				op_a = MB'(lead[cp4d_pkg::DIM_H]);
				op_b = owd_q;
			end
			JOB_LEAD_W: begin
				op_a = MB'(lead[cp4d_pkg::DIM_W]);
				op_b = RUN_W'(ext[cp4d_pkg::DIM_D]);
			end
			JOB_TRAIL_W: begin
				op_a = MB'(trail[cp4d_pkg::DIM_W]);
				op_b = RUN_W'(ext[cp4d_pkg::DIM_D]);
			end
			JOB_TRAIL_H: begin
				op_a = MB'(trail[cp4d_pkg::DIM_H]);
				op_b = owd_q;
			end
			JOB_TRAIL_B: begin
				op_a = MB'(trail[cp4d_pkg::DIM_B]);
				op_b = ohwd_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign step_last = (step_q == STEP_W'(MB - 1));
	assign prod_sat  = (|acc_q[PW-1:RUN_W]) ? {RUN_W{1'b1}} : acc_q[RUN_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cp4d_pkg::RL_IDLE:  state_nxt = cp4d_pkg::RL_IDLE;
			cp4d_pkg::RL_LOAD:  state_nxt = cp4d_pkg::RL_MUL;
			cp4d_pkg::RL_MUL:   state_nxt = step_last ? cp4d_pkg::RL_STORE : cp4d_pkg::RL_MUL;
			cp4d_pkg::RL_STORE: state_nxt = (job_q == JOB_TRAIL_B) ? cp4d_pkg::RL_IDLE
			                                                       : cp4d_pkg::RL_LOAD;
			default:            state_nxt = cp4d_pkg::RL_LOAD;
		endcase
		if (cfg_wr) begin
			state_nxt = cp4d_pkg::RL_LOAD;
		end
	end

	// outputs of the sequencer
	always_comb begin
		busy     = 1'b1;
		do_load  = 1'b0;
		do_step  = 1'b0;
		do_store = 1'b0;
		case (state_q)
			cp4d_pkg::RL_IDLE:  busy     = 1'b0;
			cp4d_pkg::RL_LOAD:  do_load  = 1'b1;
			cp4d_pkg::RL_MUL:   do_step  = 1'b1;
			cp4d_pkg::RL_STORE: do_store = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cp4d_pkg::RL_LOAD;
			job_q   <= JOB_OWD;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr) begin
				job_q <= JOB_OWD;
			end else if (do_store && job_q != JOB_TRAIL_B) begin
				job_q <= rl_job_t'(3'(job_q + 3'd1));
			end
			if (do_load) begin
				step_q <= '0;
			end else if (do_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (do_load) begin
			mplier_q <= op_a;
			mcand_q  <= PW'(op_b);
			acc_q    <= '0;
		end else if (do_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mplier_q <= mplier_q >> 1;
			mcand_q  <= mcand_q << 1;
		end
		if (do_store) begin
			case (job_q)
				JOB_OWD:     owd_q    <= prod_sat;
				JOB_OHWD:    ohwd_q   <= prod_sat;
				JOB_LEAD_B:  len_lb_q <= prod_sat;
				JOB_LEAD_H:  len_lh_q <= prod_sat;
				JOB_LEAD_W:  len_lw_q <= prod_sat;
				JOB_TRAIL_W: len_tw_q <= prod_sat;
				JOB_TRAIL_H: len_th_q <= prod_sat;
				JOB_TRAIL_B: len_tb_q <= prod_sat;
				default: ;
			endcase
		end
	end

	assign pad_len[cp4d_pkg::PAD_LEAD_B]  = len_lb_q;
	assign pad_len[cp4d_pkg::PAD_LEAD_H]  = len_lh_q;
	assign pad_len[cp4d_pkg::PAD_LEAD_W]  = len_lw_q;
	assign pad_len[cp4d_pkg::PAD_LEAD_D]  = RUN_W'(lead[cp4d_pkg::DIM_D]);
	assign pad_len[cp4d_pkg::PAD_TRAIL_D] = RUN_W'(trail[cp4d_pkg::DIM_D]);
	assign pad_len[cp4d_pkg::PAD_TRAIL_W] = len_tw_q;
	assign pad_len[cp4d_pkg::PAD_TRAIL_H] = len_th_q;
	assign pad_len[cp4d_pkg::PAD_TRAIL_B] = len_tb_q;

endmodule

`default_nettype wire

### rtl/core/constant_pad_4d_stream.sv
// ----------------------------------------------------------------------------
// constant_pad_4d_stream
// Streams a batch x height x width x depth tensor and emits the constant
// padded tensor as fill runs and element runs.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  elem     | elem_valid / elem_ready | elem_value
//  run      | run_valid / run_ready   | out_value run_length is_fill last
//           |                         | tensor_end
//  apb      | psel penable / pready   | pwrite paddr pwdata prdata
//
//  each element gives one to nine runs, one run per cycle while the run output
//  is not stalled, so interior elements stream at one per cycle between boundaries
//  a transfer on elem loads the run mask register, which then feeds the run
//  output register; the next element is taken as the last run goes out
//  after reset and after every apb write the run length unit is busy working
//  out the run lengths, and elem_ready is low while it is busy
//  a stalled run output holds the run mask and so stalls elem
//
// ----------------------------------------------------------------------------
`default_nettype none

`include "constant_pad_4d_stream_assert.svh"

module constant_pad_4d_stream #(
	parameter int DIM_BITS = cp4d_pkg::DIM_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cp4d_pkg::APB_AW-1:0]   paddr,
	input  wire logic [cp4d_pkg::APB_DW-1:0]   pwdata,
	output logic      [cp4d_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          elem_valid,
	output logic                               elem_ready,
	input  wire logic signed [cp4d_pkg::VAL_W-1:0] elem_value,
	output logic                               run_valid,
	input  wire logic                          run_ready,
	output logic signed [cp4d_pkg::VAL_W-1:0]  out_value,
	output logic      [cp4d_pkg::RUN_W-1:0]    run_length,
	output logic                               is_fill,
	output logic                               last,
	output logic                               tensor_end
);

	localparam int CFG_W = 3 * DIM_BITS;
	localparam int NR    = cp4d_pkg::NUM_RUNS;
	localparam int NP    = cp4d_pkg::NUM_PADS;
	localparam int RUN_W = cp4d_pkg::RUN_W;
	localparam int VAL_W = cp4d_pkg::VAL_W;

	logic [cp4d_pkg::NUM_DIMS-1:0][CFG_W-1:0] dim_cfg;
	logic [VAL_W-1:0]                         fill_value;
	logic                                     cfg_wr;
	logic [NP-1:0][RUN_W-1:0]                 pad_len;
	logic                                     rl_busy;

	cp4d_apb_regs #(
		.DIM_BITS (DIM_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.dim_cfg    (dim_cfg),
		.fill_value (fill_value),
		.cfg_wr     (cfg_wr)
	);

	cp4d_runlen #(
		.DIM_BITS (DIM_BITS)
	) u_runlen (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.dim_cfg (dim_cfg),
		.pad_len (pad_len),
		.busy    (rl_busy)
	);

	// coordinate counters
	logic [DIM_BITS-1:0] batch_q, row_q, col_q, chan_q;

	// per-dimension size - 1 and pad presence
	logic [cp4d_pkg::NUM_DIMS-1:0][DIM_BITS-1:0] szm1;
	logic [cp4d_pkg::NUM_DIMS-1:0]               has_lead, has_trail;

	always_comb begin
		for (int d = 0; d < cp4d_pkg::NUM_DIMS; d++) begin
			logic [DIM_BITS-1:0] sz;
			sz           = dim_cfg[d][DIM_BITS-1:0];
			szm1[d]      = (sz == '0) ? '0 : sz - DIM_BITS'(1);
			has_lead[d]  = |dim_cfg[d][2*DIM_BITS-1:DIM_BITS];
			has_trail[d] = |dim_cfg[d][CFG_W-1:2*DIM_BITS];
		end
	end

	logic open_d, open_w, open_h, open_b;
	logic close_d, close_w, close_h, close_b;

	assign open_d  = (chan_q == '0);
	assign open_w  = open_d & (col_q == '0);
	assign open_h  = open_w & (row_q == '0);
	assign open_b  = open_h & (batch_q == '0);
	assign close_d = (chan_q >= szm1[cp4d_pkg::DIM_D]);
	assign close_w = close_d & (col_q >= szm1[cp4d_pkg::DIM_W]);
	assign close_h = close_w & (row_q >= szm1[cp4d_pkg::DIM_H]);
	assign close_b = close_h & (batch_q >= szm1[cp4d_pkg::DIM_B]);

	logic [NR-1:0] mask_nxt;

	always_comb begin
		mask_nxt                      = '0;
		mask_nxt[cp4d_pkg::PAD_LEAD_B] = open_b & has_lead[cp4d_pkg::DIM_B];
		mask_nxt[cp4d_pkg::PAD_LEAD_H] = open_h & has_lead[cp4d_pkg::DIM_H];
		mask_nxt[cp4d_pkg::PAD_LEAD_W] = open_w & has_lead[cp4d_pkg::DIM_W];
		mask_nxt[cp4d_pkg::PAD_LEAD_D] = open_d & has_lead[cp4d_pkg::DIM_D];
		mask_nxt[cp4d_pkg::RUN_ELEM]   = 1'b1;
		// trailing pads sit one slot above their pad index in the mask
		mask_nxt[cp4d_pkg::PAD_TRAIL_D + 1] = close_d & has_trail[cp4d_pkg::DIM_D];
		mask_nxt[cp4d_pkg::PAD_TRAIL_W + 1] = close_w & has_trail[cp4d_pkg::DIM_W];
		mask_nxt[cp4d_pkg::PAD_TRAIL_H + 1] = close_h & has_trail[cp4d_pkg::DIM_H];
		mask_nxt[cp4d_pkg::PAD_TRAIL_B + 1] = close_b & has_trail[cp4d_pkg::DIM_B];
	end

	// stage 1: the accepted element and the runs it still owes
	logic [NR-1:0]    mask_s1;
	logic [VAL_W-1:0] val_s1;
	logic             end_s1;

	logic             s1_valid;
	logic [NR-1:0]    sel, rest;
	logic [NP-1:0]    sel_pad;
	logic             sel_last;
	logic             adv;
	logic             acc_in;
	logic [RUN_W-1:0] sel_len;

	assign s1_valid = |mask_s1;
	assign sel      = mask_s1 & (~mask_s1 + NR'(1));
	assign rest     = mask_s1 & ~sel;
	assign sel_last = (rest == '0);
	assign sel_pad  = {sel[NR-1:cp4d_pkg::RUN_ELEM+1], sel[cp4d_pkg::RUN_ELEM-1:0]};

	assign adv        = s1_valid & (~run_valid | run_ready);
	assign elem_ready = ~rl_busy & (~s1_valid | (adv & sel_last));
	assign acc_in     = elem_valid & elem_ready;

	always_comb begin
		sel_len = '0;
		for (int j = 0; j < NP; j++) begin
			if (sel_pad[j]) begin
				sel_len = sel_len | pad_len[j];
			end
		end
		if (sel[cp4d_pkg::RUN_ELEM]) begin
			sel_len = RUN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1   <= '0;
			run_valid <= 1'b0;
			batch_q   <= '0;
			row_q     <= '0;
			col_q     <= '0;
			chan_q    <= '0;
		end else begin
			if (acc_in) begin
				mask_s1 <= mask_nxt;
			end else if (adv) begin
				mask_s1 <= rest;
			end

			if (adv) begin
				run_valid <= 1'b1;
			end else if (run_ready) begin
				run_valid <= 1'b0;
			end

			// odometer step, inner dimension first
			if (acc_in) begin
				if (!close_d) begin
					chan_q <= chan_q + DIM_BITS'(1);
				end else begin
					chan_q <= '0;
					if (!close_w) begin
						col_q <= col_q + DIM_BITS'(1);
					end else begin
						col_q <= '0;
						if (!close_h) begin
							row_q <= row_q + DIM_BITS'(1);
						end else begin
							row_q <= '0;
							batch_q <= close_b ? '0 : batch_q + DIM_BITS'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			val_s1 <= elem_value;
			end_s1 <= close_b;
		end
		if (adv) begin
			out_value  <= sel[cp4d_pkg::RUN_ELEM] ? val_s1 : fill_value;
			run_length <= sel_len;
			is_fill    <= ~sel[cp4d_pkg::RUN_ELEM];
			last       <= sel_last;
			tensor_end <= sel_last & end_s1;
		end
	end

	`CP4D_ASSERT_NEXT(a_elem_run_queued, clk, arst_n, acc_in,
		mask_s1[cp4d_pkg::RUN_ELEM], "accepted element has no element run queued")

	`CP4D_ASSERT_NOW(a_fill_len_nonzero, clk, arst_n, run_valid && is_fill,
		run_length != '0, "fill run with zero length")

	`CP4D_ASSERT_NEXT(a_counters_wrap, clk, arst_n, acc_in && close_b,
		(batch_q == '0) && (row_q == '0) && (col_q == '0) && (chan_q == '0),
		"counters not cleared after tensor end")

	`CP4D_ASSERT_NEXT(a_mask_hold, clk, arst_n, s1_valid && !adv,
		$stable(mask_s1), "run mask changed while output stalled")

endmodule

`default_nettype wire

### test/pad_run_check.sv
// ----------------------------------------------------------------------------
// pad_run_check
// Follows the register writes and the element transfers of the constant pad
// stream, works out the runs each element must give and compares every run
// transfer against the oldest run still awaited.
// ----------------------------------------------------------------------------
module pad_run_check
	import cp4d_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	input  logic                     elem_valid,
	input  logic                     elem_ready,
	input  logic signed [VAL_W-1:0]  elem_value,
	input  logic                     run_valid,
	input  logic                     run_ready,
	input  logic signed [VAL_W-1:0]  out_value,
	input  logic [RUN_W-1:0]         run_length,
	input  logic                     is_fill,
	input  logic                     last,
	input  logic                     tensor_end,
	output int                       fail_count,
	output int                       pending_runs,
	output int                       elem_count,
	output int                       run_count,
	output int                       fill_count,
	output int                       tensor_count
);

	localparam int CFG_W = 3 * DIM_BITS;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [RUN_W-1:0]        len;
		logic                    fill;
		logic                    last;
		logic                    tend;
	} run_t;

	logic [CFG_W-1:0]         dim_cfg [NUM_DIMS];
	logic signed [VAL_W-1:0]  fill_val;
	logic [DIM_BITS-1:0]      coord [NUM_DIMS];
	run_t                     awaited_runs [$];
	run_t                     elem_runs [NUM_RUNS];
	int                       n_runs;
	int                       fails, reports, elems, runs, fills, tensors;

	function automatic logic [DIM_BITS-1:0] size_of(logic [CFG_W-1:0] c);
		return (c[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : c[DIM_BITS-1:0];
	endfunction

	function automatic logic [DIM_BITS-1:0] lead_of(logic [CFG_W-1:0] c);
		return c[2*DIM_BITS-1:DIM_BITS];
	endfunction

	function automatic logic [DIM_BITS-1:0] trail_of(logic [CFG_W-1:0] c);
		return c[3*DIM_BITS-1:2*DIM_BITS];
	endfunction

	function automatic logic [RUN_W-1:0] extent_of(logic [CFG_W-1:0] c);
		return RUN_W'(size_of(c)) + RUN_W'(lead_of(c)) + RUN_W'(trail_of(c));
	endfunction

	function automatic logic [RUN_W-1:0] sat_mul(logic [RUN_W-1:0] a, logic [RUN_W-1:0] b);
		logic [2*RUN_W-1:0] p;
		p = a * b;
		return (p[2*RUN_W-1:RUN_W] != '0) ? RUN_MAX : p[RUN_W-1:0];
	endfunction

	task automatic add_run(input logic signed [VAL_W-1:0] v, input logic [RUN_W-1:0] len,
			input logic fill);
		run_t r;
		r.value = v;
		r.len   = len;
		r.fill  = fill;
		r.last  = 1'b0;
		r.tend  = 1'b0;
		elem_runs[n_runs] = r;
		n_runs++;
	endtask

	// an empty pad gives no run
	task automatic add_pad(input logic [DIM_BITS-1:0] pad, input logic [RUN_W-1:0] inner);
		if (pad != '0)
			add_run(fill_val, sat_mul(RUN_W'(pad), inner), 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [RUN_W-1:0] od, owd, ohwd;
		logic open_d, open_w, open_h, open_b;
		logic close_d, close_w, close_h, close_b;
		run_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				dim_cfg[i] = CFG_W'(1);
				coord[i]   = '0;
			end
			fill_val = '0;
			awaited_runs.delete();
			fails = 0; reports = 0; elems = 0; runs = 0; fills = 0; tensors = 0;
			fail_count   <= 0;
			pending_runs <= 0;
			elem_count   <= 0;
			run_count    <= 0;
			fill_count   <= 0;
			tensor_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:3]))
					REG_BATCH:  dim_cfg[DIM_B] = pwdata[CFG_W-1:0];
					REG_HEIGHT: dim_cfg[DIM_H] = pwdata[CFG_W-1:0];
					REG_WIDTH:  dim_cfg[DIM_W] = pwdata[CFG_W-1:0];
					REG_DEPTH:  dim_cfg[DIM_D] = pwdata[CFG_W-1:0];
					REG_FILL:   fill_val = pwdata[VAL_W-1:0];
					default: ;
				endcase
			end

			if (elem_valid && elem_ready) begin
				od   = extent_of(dim_cfg[DIM_D]);
				owd  = sat_mul(extent_of(dim_cfg[DIM_W]), od);
				ohwd = sat_mul(extent_of(dim_cfg[DIM_H]), owd);
				open_d  = coord[DIM_D] == '0;
				open_w  = open_d && coord[DIM_W] == '0;
				open_h  = open_w && coord[DIM_H] == '0;
				open_b  = open_h && coord[DIM_B] == '0;
				// counters left high by a config change also close their dimension
				close_d = coord[DIM_D] >= size_of(dim_cfg[DIM_D]) - 1'b1;
				close_w = close_d && coord[DIM_W] >= size_of(dim_cfg[DIM_W]) - 1'b1;
				close_h = close_w && coord[DIM_H] >= size_of(dim_cfg[DIM_H]) - 1'b1;
				close_b = close_h && coord[DIM_B] >= size_of(dim_cfg[DIM_B]) - 1'b1;

				n_runs = 0;
				if (open_b) add_pad(lead_of(dim_cfg[DIM_B]), ohwd);
				if (open_h) add_pad(lead_of(dim_cfg[DIM_H]), owd);
				if (open_w) add_pad(lead_of(dim_cfg[DIM_W]), od);
				if (open_d) add_pad(lead_of(dim_cfg[DIM_D]), RUN_W'(1));
				add_run(elem_value, RUN_W'(1), 1'b0);
				if (close_d) add_pad(trail_of(dim_cfg[DIM_D]), RUN_W'(1));
				if (close_w) add_pad(trail_of(dim_cfg[DIM_W]), od);
				if (close_h) add_pad(trail_of(dim_cfg[DIM_H]), owd);
				if (close_b) add_pad(trail_of(dim_cfg[DIM_B]), ohwd);

				want = elem_runs[n_runs-1];
				want.last = 1'b1;
				want.tend = close_b;
				elem_runs[n_runs-1] = want;
				for (int i = 0; i < n_runs; i++)
					awaited_runs.push_back(elem_runs[i]);

				if (!close_d) begin
					coord[DIM_D] = coord[DIM_D] + 1'b1;
				end else begin
					coord[DIM_D] = '0;
					if (!close_w) begin
						coord[DIM_W] = coord[DIM_W] + 1'b1;
					end else begin
						coord[DIM_W] = '0;
						if (!close_h) begin
							coord[DIM_H] = coord[DIM_H] + 1'b1;
						end else begin
							coord[DIM_H] = '0;
							if (!close_b)
								coord[DIM_B] = coord[DIM_B] + 1'b1;
							else
								coord[DIM_B] = '0;
						end
					end
				end
				elems++;
				if (close_b)
					tensors++;
			end

			if (run_valid && run_ready) begin
				got.value = out_value;
				got.len   = run_length;
				got.fill  = is_fill;
				got.last  = last;
				got.tend  = tensor_end;
				runs++;
				if (is_fill)
					fills++;
				if (awaited_runs.size() == 0) begin
					fails++;
					if (reports < 10) begin
						reports++;
						$display("unexpected run transfer: value %h len %0d fill %b last %b end %b",
							got.value, got.len, got.fill, got.last, got.tend);
					end
				end else begin
					want = awaited_runs.pop_front();
					if (got !== want) begin
						fails++;
						if (reports < 10) begin
							reports++;
							$display("run %0d mismatch (exp/got): value %h/%h len %0d/%0d",
								runs, want.value, got.value, want.len, got.len);
							$display("  fill %b/%b last %b/%b end %b/%b",
								want.fill, got.fill, want.last, got.last, want.tend, got.tend);
						end
					end
				end
			end

			fail_count   <= fails;
			pending_runs <= awaited_runs.size();
			elem_count   <= elems;
			run_count    <= runs;
			fill_count   <= fills;
			tensor_count <= tensors;
		end
	end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the constant pad stream: directed tensors at the size, pad
// and value extremes, then random tensor shapes with config changes that
// land mid-tensor, under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
	import cp4d_pkg::*;

	localparam int DB          = DIM_BITS_DEF;
	localparam int ITEMS       = 230;
	localparam int STALL_LIMIT = 2000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     elem_valid = 1'b0;
	logic                     elem_ready;
	logic signed [VAL_W-1:0]  elem_value = '0;
	logic                     run_valid;
	logic                     run_ready = 1'b0;
	logic signed [VAL_W-1:0]  out_value;
	logic [RUN_W-1:0]         run_length;
	logic                     is_fill;
	logic                     last;
	logic                     tensor_end;

	int fail_count, pending_runs, elem_count, run_count, fill_count, tensor_count;
	int items_sent = 0;
	int reg_writes = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	int stall_cycles = 0;

	constant_pad_4d_stream dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem_value (elem_value),
		.run_valid  (run_valid),
		.run_ready  (run_ready),
		.out_value  (out_value),
		.run_length (run_length),
		.is_fill    (is_fill),
		.last       (last),
		.tensor_end (tensor_end)
	);

	pad_run_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.elem_valid   (elem_valid),
		.elem_ready   (elem_ready),
		.elem_value   (elem_value),
		.run_valid    (run_valid),
		.run_ready    (run_ready),
		.out_value    (out_value),
		.run_length   (run_length),
		.is_fill      (is_fill),
		.last         (last),
		.tensor_end   (tensor_end),
		.fail_count   (fail_count),
		.pending_runs (pending_runs),
		.elem_count   (elem_count),
		.run_count    (run_count),
		.fill_count   (fill_count),
		.tensor_count (tensor_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk)
		run_ready <= ($urandom_range(99) >= rcv_idle);

	// ends the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (elem_valid && elem_ready) || (run_valid && run_ready) || psel) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("constant_pad_4d_stream regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// upper bits beyond the register width are junk the block must drop
	function automatic logic [APB_DW-1:0] dim_word(int size, int lead, int trail);
		logic [APB_DW-1:0] w;
		w = {$urandom(), $urandom()};
		w[3*DB-1:0] = {DB'(trail), DB'(lead), DB'(size)};
		return w;
	endfunction

	function automatic int rand_field(int small_max);
		return ($urandom_range(9) == 0) ? $urandom_range((1 << DB) - 1) : $urandom_range(small_max);
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic apb_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
	endtask

	task automatic send_elem(input logic [VAL_W-1:0] v);
		if (items_sent < ITEMS / 3) begin
			snd_idle = 8;
			rcv_idle <= 75;
		end else if (items_sent < 2 * ITEMS / 3) begin
			snd_idle = 75;
			rcv_idle <= 8;
		end else begin
			snd_idle = 0;
			rcv_idle <= 0;
		end
		while ($urandom_range(99) < snd_idle) begin
			elem_valid <= 1'b0;
			@(posedge clk);
		end
		elem_valid <= 1'b1;
		elem_value <= v;
		do @(posedge clk); while (!elem_ready);
		items_sent++;
	endtask

	task automatic drain();
		elem_valid <= 1'b0;
		@(posedge clk);
		while (pending_runs != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset shape: every element is a whole tensor with no padding
		send_elem(32'h7fff_ffff);
		send_elem(32'h8000_0000);
		send_elem(32'h0000_0000);
		send_elem(32'hffff_ffff);
		drain();

		// small tensor with a zero size field, walked to the end
		apb_write(REG_BATCH, dim_word(2, 1, 2));
		apb_write(REG_HEIGHT, dim_word(0, 3, 0));
		apb_write(REG_WIDTH, dim_word(2, 0, 1));
		apb_write(REG_DEPTH, dim_word(2, 2, 1));
		apb_write(REG_FILL, {$urandom(), 32'h8000_0000});
		send_elem(32'h5555_5555);
		send_elem(32'haaaa_aaaa);
		repeat (6) send_elem(rand_value());
		drain();

		// unit sizes with full pads: every element opens and closes all dimensions
		for (int i = REG_BATCH; i <= REG_DEPTH; i++)
			apb_write(reg_idx_t'(i), dim_word(0, (1 << DB) - 1, (1 << DB) - 1));
		apb_write(REG_FILL, {$urandom(), 32'h7fff_ffff});
		send_elem($urandom());
		send_elem($urandom());
		drain();

		// largest sizes and pads, left unfinished so the next shape lands mid-tensor
		for (int i = REG_BATCH; i <= REG_DEPTH; i++)
			apb_write(reg_idx_t'(i), dim_word((1 << DB) - 1, (1 << DB) - 1, (1 << DB) - 1));
		apb_write(REG_FILL, {$urandom(), 32'hffff_ffff});
		repeat (3) send_elem(rand_value());
		drain();

		while (items_sent < ITEMS) begin
			for (int i = REG_BATCH; i <= REG_DEPTH; i++)
				if ($urandom_range(2) != 0)
					apb_write(reg_idx_t'(i), dim_word(rand_field(3), rand_field(2),
						rand_field(2)));
			if ($urandom_range(1) != 0)
				apb_write(REG_FILL, {$urandom(), $urandom()});
			n = $urandom_range(6, 30);
			repeat (n) send_elem(rand_value());
			drain();
		end

		repeat (40) @(posedge clk);
		$display("sent %0d elements over %0d register writes", elem_count, reg_writes);
		$display("checked %0d runs, %0d of them fill runs, %0d tensors closed",
			run_count, fill_count, tensor_count);
		if (fail_count == 0)
			$display("constant_pad_4d_stream regression: pass");
		else
			$display("constant_pad_4d_stream regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/cp4d_pkg.sv
rtl/core/cp4d_apb_regs.sv
rtl/core/cp4d_runlen.sv
rtl/core/constant_pad_4d_stream.sv
test/pad_run_check.sv
test/tb.sv
